FILE: hw/rtl/broe_pkg.sv
package broe_pkg;

  localparam int unsigned RateW   = 64;
  localparam int unsigned KbpsW   = RateW - 10;
  localparam int unsigned RemW    = 18;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned CountW  = 2;
  localparam int unsigned LenW    = 4;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 32;

  // element kinds carried on the input tuser bit
  localparam logic KindAggregate = 1'b0;
  localparam logic KindBearer    = 1'b1;

  localparam logic [KbpsW-1:0] KbHighLimit = KbpsW'(65200 * 1024);

  // range bounds in kbps on the remainder below 256*1024
  localparam logic [RemW-1:0] RemStep8Lo    = RemW'(64);
  localparam logic [RemW-1:0] RemStep8Hi    = RemW'(568);
  localparam logic [RemW-1:0] RemStep64Lo   = RemW'(576);
  localparam logic [RemW-1:0] RemStep64Hi   = RemW'(8640);
  localparam logic [RemW-1:0] RemStep100Lo  = RemW'(8700);
  localparam logic [RemW-1:0] RemStep100Hi  = RemW'(16000);
  localparam logic [RemW-1:0] RemStep100Off = RemW'(8600);
  localparam logic [RemW-1:0] RemStep1kLo   = RemW'(17 * 1024);
  localparam logic [RemW-1:0] RemStep1kHi   = RemW'(128 * 1024);
  localparam logic [RemW-1:0] RemStep1kOff  = RemW'(16 * 1024);
  localparam logic [RemW-1:0] RemStep2kLo   = RemW'(130 * 1024);
  localparam logic [RemW-1:0] RemStep2kOff  = RemW'(128 * 1024);

  // floor(x / 100) = (x * 5243) >> 19 for x below 8192
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;

  localparam logic [OctetW-1:0] OctZero     = 8'hFF;
  localparam logic [OctetW-1:0] OctBase8    = 8'b0100_0000;
  localparam logic [OctetW-1:0] OctBaseTop8 = 8'b0111_1111;
  localparam logic [OctetW-1:0] OctBase64   = 8'b1000_0000;
  localparam logic [OctetW-1:0] OctBaseExt  = 8'b1111_1110;
  localparam logic [OctetW-1:0] OctExt1k    = 8'b0100_1010;
  localparam logic [OctetW-1:0] OctExt2k    = 8'b1011_1010;
  localparam logic [OctetW-1:0] OctHighSat  = 8'hFE;

  typedef struct packed {
    logic [OctetW-1:0] rate_octet;
    logic [OctetW-1:0] extension_octet;
    logic [OctetW-1:0] high_extension_octet;
    logic [CountW-1:0] octet_count;
  } broe_octets_t;

endpackage

FILE: hw/rtl/broe_encode.sv
module broe_encode
  import broe_pkg::*;
(
  input  logic [KbpsW-1:0] kbps_i,
  input  logic             req_type_i,
  output broe_octets_t     octets_o
);

  logic              high_used;
  logic [RemW-1:0]   rem;
  logic [9:0]        t8;
  logic [13:0]       t64;
  logic [12:0]       t100;
  logic [25:0]       prod100;
  logic [RemW-1:0]   t1k;
  logic [RemW-1:0]   t2k;
  logic [CountW-1:0] low_count;

  assign high_used = |kbps_i[KbpsW-1:RemW];
  assign rem       = kbps_i[RemW-1:0];

  assign t8      = rem[9:0] - 10'(RemStep8Lo);
  assign t64     = rem[13:0] - 14'(RemStep64Lo);
  assign t100    = 13'(rem[13:0] - 14'(RemStep100Off));
  assign prod100 = 26'(t100) * 26'(Div100Mul);
  assign t1k     = rem - RemStep1kOff;
  assign t2k     = rem - RemStep2kOff;

  always_comb begin
    octets_o = '0;
    low_count = 2'd1;
    if (rem == '0) begin
      low_count = 2'd0;
    end else if (rem < RemStep8Lo) begin
      octets_o.rate_octet = rem[7:0];
    end else if (rem <= RemStep8Hi) begin
      octets_o.rate_octet = 8'(t8[9:3]) + OctBase8;
    end else if (rem < RemStep64Lo) begin
      octets_o.rate_octet = OctBaseTop8;
    end else if (rem <= RemStep64Hi) begin
      octets_o.rate_octet = t64[13:6] + OctBase64;
    end else if (rem < RemStep100Lo) begin
      octets_o.rate_octet = OctBaseExt;
    end else begin
      low_count = 2'd2;
      octets_o.rate_octet = OctBaseExt;
      if (rem <= RemStep100Hi) begin
        octets_o.extension_octet = 8'(prod100[Div100Shift +: 7]);
      end else if (rem < RemStep1kLo) begin
        octets_o.extension_octet = OctExt1k;
      end else if (rem <= RemStep1kHi) begin
        octets_o.extension_octet = t1k[17:10] + OctExt1k;
      end else if (rem < RemStep2kLo) begin
        octets_o.extension_octet = OctExt2k;
      end else begin
        octets_o.extension_octet = 8'(t2k[17:11]) + OctExt2k;
      end
    end

    if (high_used) begin
      octets_o.octet_count = 2'd3;
      octets_o.high_extension_octet =
        (kbps_i > KbHighLimit) ? OctHighSat : kbps_i[25:18];
    end else if (kbps_i == '0) begin
      // zero kbps: marker octet for aggregate, nothing for bearer
      octets_o = '0;
      if (req_type_i == KindAggregate) begin
        octets_o.rate_octet  = OctZero;
        octets_o.octet_count = 2'd1;
      end
    end else begin
      octets_o.octet_count = low_count;
    end
  end

endmodule

FILE: hw/rtl/broe_group_len.sv
module broe_group_len
  import broe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [CountW-1:0] octet_count_i,
  input  logic              req_type_i,
  input  logic              last_i,
  output logic [LenW-1:0]   element_length_o
);

  logic [CountW-1:0] max_q, max_d;
  logic [CountW-1:0] max_new;

  assign max_new = (octet_count_i > max_q) ? octet_count_i : max_q;

  always_comb begin
    element_length_o = '0;
    if (last_i) begin
      element_length_o = (req_type_i == KindBearer) ?
        LenW'({max_new, 2'b01}) : LenW'({max_new, 1'b0});
    end
    max_d = max_q;
    if (advance_i) begin
      max_d = last_i ? '0 : max_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  // group closes: maximum starts over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && last_i) |=> (max_q == '0))
    else $error("group maximum not cleared after last beat");

  // maximum never falls inside a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !last_i) |=> (max_q >= $past(max_q)))
    else $error("group maximum decreased within a group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && last_i && req_type_i == KindBearer) |-> element_length_o[0])
    else $error("bearer element length must be odd");

endmodule

FILE: hw/rtl/bit_rate_octet_encoder_core.sv
// Bit rate octet encoder.
// Input stream (s_axis): one rate per beat. tdata carries the rate in bits
// per second, tuser selects the element kind (0 aggregate, 1 bearer) and
// tlast marks the last rate of an element's group.
// Output stream (m_axis): one result per input beat, in order. tdata carries
// the base, extended and second extended rate octets, the octet count and the
// element length; tlast repeats the input tlast and flags the length as valid.
// Rates are floored to kbps and encoded piecewise; a running maximum of the
// octet count over the group yields the length on the last beat, then clears.
// Path: an accepted beat is held in the input register, then in the result
// register that drives m_axis.
// Throughput: one beat per cycle unless the receiver stalls; encoding and the
// group maximum both settle in the single logic stage between the two registers.
// Reset empties both registers and clears the group maximum.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; s_axis_tready drops once both are full.
module bit_rate_octet_encoder_core
  import broe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [63:0] rate_bps
  input  logic                s_axis_tuser,  // [0] req_type
  input  logic                s_axis_tlast,  // last_rate
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [7:0] rate_octet, [15:8] extension_octet,
                                             // [23:16] high_extension_octet,
                                             // [25:24] octet_count, [29:26] element_length
  output logic                m_axis_tlast   // length_valid
);

  logic             in_v_q, in_v_d;
  logic [KbpsW-1:0] kbps_q;
  logic             type_q;
  logic             last_q;

  logic                out_v_q, out_v_d;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  logic         out_free;
  logic         advance;
  logic         take;
  broe_octets_t octets;
  logic [LenW-1:0] elem_len;

  assign out_free      = !out_v_q || m_axis_tready;
  assign advance       = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || out_free;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (take) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kbps_q <= s_axis_tdata[RateW-1:10];
      type_q <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_data_q <= {2'b00, elem_len, octets.octet_count, octets.high_extension_octet,
                     octets.extension_octet, octets.rate_octet};
      out_last_q <= last_q;
    end
  end

  broe_encode u_encode (
    .kbps_i     (kbps_q),
    .req_type_i (type_q),
    .octets_o   (octets)
  );

  broe_group_len u_group_len (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .octet_count_i    (octets.octet_count),
    .req_type_i       (type_q),
    .last_i           (last_q),
    .element_length_o (elem_len)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[29:26] == '0))
    else $error("element length set on a beat that is not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[25:24] == 2'd0) |-> (m_axis_tdata[23:0] == '0))
    else $error("octets present with zero octet count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[23:16] != '0) |-> (m_axis_tdata[25:24] == 2'd3))
    else $error("second extended octet used without count of three");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_free) |=> (in_v_q && $stable(kbps_q)))
    else $error("staged rate lost while output stalled");

endmodule
